>>> rtl/bmie_pkg.sv
`default_nettype none

package bmie_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned LG_W   = 3;
  localparam int unsigned CNT_W  = 7;

  // element size is 2**lg, lg in 1..6; a 64-bit element always repeats
  localparam logic [LG_W-1:0]  LG_MIN  = 3'd1;
  localparam logic [LG_W-1:0]  LG_FULL = 3'd6;
  localparam logic [CNT_W-1:0] NIMMS_BASE = 7'h3F;

  // location of the single run start inside an element
  typedef struct packed {
    logic             single;
    logic [POS_W-1:0] pos;
  } run_info_t;

  // balanced adder tree, six levels deep
  function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [1:0] p2  [32];
    logic [2:0] p4  [16];
    logic [3:0] p8  [8];
    logic [4:0] p16 [4];
    logic [5:0] p32 [2];
    for (int i = 0; i < 32; i++) begin
      p2[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      p8[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      p16[i] = {1'b0, p8[2*i]} + {1'b0, p8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      p32[i] = {1'b0, p16[2*i]} + {1'b0, p16[2*i+1]};
    end
    return {1'b0, p32[0]} + {1'b0, p32[1]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/bmie_run_locate.sv
`default_nettype none

module bmie_run_locate (
  input  wire logic [bmie_pkg::WORD_W-1:0] edges,
  output bmie_pkg::run_info_t              info
);
  import bmie_pkg::*;

  logic [POS_W-1:0] pos;
  logic             single;

  // a valid element has exactly one rising edge (0 below, 1 above)
  always_comb begin
    single = (edges != '0) && ((edges & (edges - WORD_W'(1))) == '0);
  end

  // OR-encode the index; only meaningful when one bit is set
  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (edges[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  assign info.single = single;
  assign info.pos    = pos;

endmodule

`default_nettype wire

>>> rtl/bitmask_immediate_encoder_core.sv
`default_nettype none

// Channel | Handshake         | Payload
// --------+-------------------+----------------------------------
// input   | in_valid/in_ready | value[63:0]
// output  | out_valid/out_ready | encodable, n_bit, immr[5:0], imms[5:0]
//
// Five register stages: input, period check, element/edge extract,
// run locate plus popcount, field pack. One value per cycle is taken
// while the output is drained.
// Each stage holds its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up under an output stall.
// rst clears the valid bits only.

module bitmask_immediate_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             encodable,
  output logic             n_bit,
  output logic [5:0]       immr,
  output logic [5:0]       imms
);
  import bmie_pkg::*;

  localparam int unsigned STAGES = 5;
  localparam int unsigned REP_N  = 5;

  logic [STAGES-1:0] stg_valid;
  logic [STAGES-1:0] stg_en;

  // stage registers
  logic [WORD_W-1:0] value1;
  logic [WORD_W-1:0] value2;
  logic [REP_N-1:0]  rep2;
  logic              special2;
  logic [WORD_W-1:0] elem3;
  logic [WORD_W-1:0] edges3;
  logic [LG_W-1:0]   lg3;
  logic              special3;
  run_info_t         run4;
  logic [CNT_W-1:0]  ones4;
  logic [LG_W-1:0]   lg4;
  logic              special4;
  logic              enc5;
  logic              n5;
  logic [POS_W-1:0]  immr5;
  logic [POS_W-1:0]  imms5;

  // per-stage enables, output side first
  always_comb begin
    stg_en[STAGES-1] = !stg_valid[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stg_en[k] = !stg_valid[k] || stg_en[k+1];
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = stg_valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (stg_en[0]) begin
        stg_valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stg_en[k]) begin
          stg_valid[k] <= stg_valid[k-1];
        end
      end
    end
  end

  // stage 1: capture input
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      value1 <= value;
    end
  end

  // stage 2: period check for element sizes 2..32, zero / all-ones detect
  logic [REP_N-1:0] rep1;
  always_comb begin
    for (int k = 1; k <= REP_N; k++) begin
      rep1[k-1] = (value1 == ((value1 << (1 << k)) | (value1 >> (WORD_W - (1 << k)))));
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      value2   <= value1;
      rep2     <= rep1;
      special2 <= (value1 == '0) || (value1 == '1);
    end
  end

  // stage 3: smallest repeating size, element and its circular rising edges
  logic [LG_W-1:0]   lg2;
  logic [CNT_W-1:0]  size2;
  logic [WORD_W-1:0] mask2;
  always_comb begin
    lg2 = LG_FULL;
    for (int k = REP_N; k >= 1; k--) begin
      if (rep2[k-1]) begin
        lg2 = LG_W'(k);
      end
    end
    size2 = CNT_W'(1) << lg2;
    mask2 = {WORD_W{1'b1}} >> (CNT_W'(WORD_W) - size2);
  end

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      elem3    <= value2 & mask2;
      edges3   <= value2 & ~{value2[WORD_W-2:0], value2[WORD_W-1]} & mask2;
      lg3      <= lg2;
      special3 <= special2;
    end
  end

  // stage 4: locate the run start and count its length
  run_info_t run3;
  bmie_run_locate u_locate (
    .edges (edges3),
    .info  (run3)
  );

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      run4     <= run3;
      ones4    <= popcount64(elem3);
      lg4      <= lg3;
      special4 <= special3;
    end
  end

  // stage 5: immr = (size - start) mod size, N:imms from size and length
  logic [CNT_W-1:0] size4;
  logic [CNT_W-1:0] rot4;
  logic [CNT_W-1:0] nimms4;
  logic             enc4;
  always_comb begin
    size4  = CNT_W'(1) << lg4;
    rot4   = (size4 - {1'b0, run4.pos}) & (size4 - CNT_W'(1));
    nimms4 = ((NIMMS_BASE ^ size4) & ~(size4 - CNT_W'(1))) | (ones4 - CNT_W'(1));
    enc4   = run4.single && !special4 && (lg4 >= LG_MIN);
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      enc5  <= enc4;
      n5    <= enc4 && nimms4[CNT_W-1];
      immr5 <= enc4 ? rot4[POS_W-1:0] : '0;
      imms5 <= enc4 ? nimms4[POS_W-1:0] : '0;
    end
  end

  assign encodable = enc5;
  assign n_bit     = n5;
  assign immr      = immr5;
  assign imms      = imms5;

endmodule

`default_nettype wire
